// ----- sv/sha256_pkg.sv -----
`default_nettype none

package sha256_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } t_state;

    // padding marker and the fill level where the length field starts
    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    // round constants
    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    // initial hash value
    localparam logic [31:0] HASH_IV [0:7] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

endpackage

`default_nettype wire

// ----- sv/sha256_stream_hasher.sv -----
// SHA-256 over a byte stream. Each input word carries one message byte in tdata, tuser set
// when the byte is valid and tlast closing the message. A byte is taken whenever the block
// is idle; the 64th byte of a block starts the single round unit, which runs 64 rounds and
// then folds the result into the hash, and the input is not ready during compression. On
// tlast the padding bytes and the 8-byte bit length are shifted in one per cycle, pausing
// while a full block is compressed when the length needs a second block; one or two
// compressions follow, then the digest leaves as four 64-bit words, most significant
// first, and the block returns to its initial state.
`default_nettype none

module sha256_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] byte_present
    input  wire logic        i_s_axis_tlast,   // end_of_message
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,   // [63:0] digest_part
    output logic [1:0]       o_m_axis_tuser,   // [1:0] part_index
    output logic             o_m_axis_tlast    // last_part
);

    sha256_pkg::t_state r_state, n_state;
    logic [31:0]  r_hash [0:7];
    logic [31:0]  n_hash [0:7];
    logic [31:0]  r_wrk  [0:7];
    logic [31:0]  n_wrk  [0:7];
    logic [511:0] r_blk, n_blk;
    logic [5:0]   r_fill, n_fill;
    logic [60:0]  r_total, n_total;
    logic [5:0]   r_round, n_round;
    logic [1:0]   r_part, n_part;
    logic         r_closing, n_closing;
    logic         r_pad_first, n_pad_first;
    logic         r_len_done, n_len_done;

    logic         push;
    logic [7:0]   push_byte;
    logic         start_comp;
    logic [63:0]  bit_len;
    logic [7:0]   len_byte;
    logic [31:0]  w_cur, w_new, t1, t2;

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        small_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        small_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    // length field bytes, most significant first while fill runs 56..63
    assign bit_len  = {r_total, 3'b000};
    assign len_byte = bit_len[63 - {r_fill[2:0], 3'b000} -: 8];

    // message schedule from the sliding 16-word window, oldest word on top
    assign w_cur = r_blk[511:480];
    assign w_new = w_cur + small_s0(r_blk[479:448]) + r_blk[223:192]
                 + small_s1(r_blk[63:32]);

    // shared round unit
    assign t1 = r_wrk[7] + big_s1(r_wrk[4])
              + ((r_wrk[4] & r_wrk[5]) ^ (~r_wrk[4] & r_wrk[6]))
              + sha256_pkg::ROUND_K[r_round] + w_cur;
    assign t2 = big_s0(r_wrk[0])
              + ((r_wrk[0] & r_wrk[1]) ^ (r_wrk[0] & r_wrk[2]) ^ (r_wrk[1] & r_wrk[2]));

    // output word straight from the hash registers
    assign o_m_axis_tdata = {r_hash[{r_part, 1'b0}], r_hash[{r_part, 1'b1}]};
    assign o_m_axis_tuser = r_part;
    assign o_m_axis_tlast = (r_part == 2'd3);

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_wrk       = r_wrk;
        n_blk       = r_blk;
        n_fill      = r_fill;
        n_total     = r_total;
        n_round     = r_round;
        n_part      = r_part;
        n_closing   = r_closing;
        n_pad_first = r_pad_first;
        n_len_done  = r_len_done;
        push        = 1'b0;
        push_byte   = 8'h00;
        start_comp  = 1'b0;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;

        case (r_state)
            sha256_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (i_s_axis_tuser) begin
                        push      = 1'b1;
                        push_byte = i_s_axis_tdata;
                        n_total   = r_total + 61'd1;
                    end
                    if (i_s_axis_tlast) begin
                        n_closing   = 1'b1;
                        n_pad_first = 1'b1;
                    end
                    if (i_s_axis_tuser && r_fill == 6'd63) begin
                        start_comp = 1'b1;
                    end else if (i_s_axis_tlast) begin
                        n_state = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                push        = 1'b1;
                push_byte   = r_pad_first ? sha256_pkg::PAD_MARK : 8'h00;
                n_pad_first = 1'b0;
                if (r_fill == 6'd63) begin
                    start_comp = 1'b1;
                end else if (r_fill == sha256_pkg::LEN_START - 6'd1) begin
                    n_state = sha256_pkg::ST_LEN;
                end
            end
            sha256_pkg::ST_LEN: begin
                push      = 1'b1;
                push_byte = len_byte;
                if (r_fill == 6'd63) begin
                    start_comp = 1'b1;
                    n_len_done = 1'b1;
                end
            end
            sha256_pkg::ST_ROUND: begin
                n_wrk[7] = r_wrk[6];
                n_wrk[6] = r_wrk[5];
                n_wrk[5] = r_wrk[4];
                n_wrk[4] = r_wrk[3] + t1;
                n_wrk[3] = r_wrk[2];
                n_wrk[2] = r_wrk[1];
                n_wrk[1] = r_wrk[0];
                n_wrk[0] = t1 + t2;
                n_blk    = {r_blk[479:0], w_new};
                n_round  = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = sha256_pkg::ST_UPDATE;
                end
            end
            sha256_pkg::ST_UPDATE: begin
                for (int i = 0; i < 8; i++) begin
                    n_hash[i] = r_hash[i] + r_wrk[i];
                end
                if (!r_closing) begin
                    n_state = sha256_pkg::ST_IDLE;
                end else if (r_len_done) begin
                    n_state = sha256_pkg::ST_OUT;
                    n_part  = 2'd0;
                end else begin
                    n_state = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_OUT: begin
                o_m_axis_tvalid = 1'b1;
                if (i_m_axis_tready) begin
                    if (r_part == 2'd3) begin
                        n_hash      = sha256_pkg::HASH_IV;
                        n_fill      = 6'd0;
                        n_total     = 61'd0;
                        n_closing   = 1'b0;
                        n_pad_first = 1'b0;
                        n_len_done  = 1'b0;
                        n_state     = sha256_pkg::ST_IDLE;
                    end else begin
                        n_part = r_part + 2'd1;
                    end
                end
            end
            default: begin
                n_state = sha256_pkg::ST_IDLE;
            end
        endcase

        // shift a byte into the block, fill wraps to zero on a full block
        if (push) begin
            n_blk  = {r_blk[503:0], push_byte};
            n_fill = r_fill + 6'd1;
        end

        // load the working variables for a new block
        if (start_comp) begin
            n_wrk   = r_hash;
            n_round = 6'd0;
            n_state = sha256_pkg::ST_ROUND;
        end
    end

    // control and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sha256_pkg::ST_IDLE;
            r_hash      <= sha256_pkg::HASH_IV;
            r_fill      <= 6'd0;
            r_total     <= 61'd0;
            r_round     <= 6'd0;
            r_part      <= 2'd0;
            r_closing   <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_done  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_round     <= n_round;
            r_part      <= n_part;
            r_closing   <= n_closing;
            r_pad_first <= n_pad_first;
            r_len_done  <= n_len_done;
        end
    end

    // block window and working variables
    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_wrk <= n_wrk;
    end

    // input and output never open at the same time
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while digest is pending");

    // last digest word returns the block to an empty message
    a_clean_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=>
        (r_fill == 6'd0 && r_total == 61'd0 && r_state == sha256_pkg::ST_IDLE))
        else $error("state not cleared after digest");

    // the final round hands over to the hash update
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256_pkg::ST_ROUND && r_round == 6'd63) |=>
        (r_state == sha256_pkg::ST_UPDATE))
        else $error("round count did not end in update");

    // the length field only goes into the last eight bytes of a block
    a_len_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256_pkg::ST_LEN) |-> (r_fill >= sha256_pkg::LEN_START))
        else $error("length field misplaced");

endmodule

`default_nettype wire

// ----- tb/sv/sha256_digest_checker.sv -----
module sha256_digest_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tuser,   // [0] byte_present
    input  wire logic        i_s_tlast,   // end_of_message
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [63:0] i_m_tdata,   // [63:0] digest_part
    input  wire logic [1:0]  i_m_tuser,   // [1:0] part_index
    input  wire logic        i_m_tlast,   // last_part
    output int               o_fail_count,
    output int               o_words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] part;
        logic [1:0]  index;
        logic        last;
    } t_digest_word;

    // running hash of the open message, word 0 in the top bits
    logic [255:0]  chain_value = '0;
    // bytes of the current block, byte 0 in the top bits
    logic [511:0]  block_buf   = '0;
    int            block_fill  = 0;
    logic [60:0]   msg_bytes   = '0;
    t_digest_word  digest_due[$];
    t_digest_word  want;
    int            fail_total  = 0;
    int            due_count   = 0;

    assign o_fail_count = fail_total;
    assign o_words_due  = due_count;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // one 64-round compression of a 512-bit block into the chain value
    function automatic logic [255:0] sha_compress(input logic [255:0] hv,
                                                  input logic [511:0] blk);
        logic [31:0]  w [64];
        logic [31:0]  r [8];
        logic [31:0]  s0, s1, t1, t2;
        logic [255:0] res;
        int           i;
        for (i = 0; i < 16; i++)
            w[i] = blk[511 - 32 * i -: 32];
        for (i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (i = 0; i < 8; i++)
            r[i] = hv[255 - 32 * i -: 32];
        for (i = 0; i < 64; i++) begin
            t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
                 + ((r[4] & r[5]) ^ (~r[4] & r[6])) + sha256_pkg::ROUND_K[i] + w[i];
            t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
                 + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            r[7] = r[6];
            r[6] = r[5];
            r[5] = r[4];
            r[4] = r[3] + t1;
            r[3] = r[2];
            r[2] = r[1];
            r[1] = r[0];
            r[0] = t1 + t2;
        end
        for (i = 0; i < 8; i++)
            res[255 - 32 * i -: 32] = hv[255 - 32 * i -: 32] + r[i];
        return res;
    endfunction

    task automatic clear_message();
        int i;
        for (i = 0; i < 8; i++)
            chain_value[255 - 32 * i -: 32] = sha256_pkg::HASH_IV[i];
        block_buf  = '0;
        block_fill = 0;
        msg_bytes  = '0;
    endtask

    // fold one accepted input word into the hash, queue the digest on end of message
    task automatic absorb_word(input logic [7:0] data, input logic present,
                               input logic last);
        logic [1023:0] tail;
        logic [63:0]   bit_len;
        t_digest_word  dw;
        int            k;
        if (present) begin
            block_buf[511 - 8 * block_fill -: 8] = data;
            block_fill++;
            msg_bytes++;
            if (block_fill == 64) begin
                chain_value = sha_compress(chain_value, block_buf);
                block_fill  = 0;
            end
        end
        if (last) begin
            // only bytes of the current block are copied into the padding
            tail = '0;
            for (k = 0; k < block_fill; k++)
                tail[1023 - 8 * k -: 8] = block_buf[511 - 8 * k -: 8];
            tail[1023 - 8 * block_fill -: 8] = sha256_pkg::PAD_MARK;
            bit_len = {msg_bytes, 3'b000};
            if (block_fill < int'(sha256_pkg::LEN_START)) begin
                tail[575:512] = bit_len;
                chain_value   = sha_compress(chain_value, tail[1023:512]);
            end else begin
                // length does not fit, a second padding block follows
                tail[63:0]  = bit_len;
                chain_value = sha_compress(chain_value, tail[1023:512]);
                chain_value = sha_compress(chain_value, tail[511:0]);
            end
            for (k = 0; k < 4; k++) begin
                dw.part  = chain_value[255 - 64 * k -: 64];
                dw.index = 2'(k);
                dw.last  = (k == 3);
                digest_due.push_back(dw);
            end
            clear_message();
        end
    endtask

    // watch both channels on every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_message();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (digest_due.size() == 0) begin
                    $display("%0t: unexpected digest word: expected none, ", $time,
                             "got data %h index %0d last %b",
                             i_m_tdata, i_m_tuser, i_m_tlast);
                    fail_total++;
                end else begin
                    want = digest_due.pop_front();
                    if (i_m_tdata !== want.part || i_m_tuser !== want.index ||
                        i_m_tlast !== want.last) begin
                        $display("%0t: digest word mismatch: ", $time,
                                 "expected data %h index %0d last %b, ",
                                 want.part, want.index, want.last,
                                 "got data %h index %0d last %b",
                                 i_m_tdata, i_m_tuser, i_m_tlast);
                        fail_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                absorb_word(i_s_tdata, i_s_tuser, i_s_tlast);
        end
        due_count = digest_due.size();
    end

endmodule

// ----- tb/sv/sha256_stream_hasher_test.sv -----
module sha256_stream_hasher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int SHORT_MSG_TARGET = 90;
    localparam int DRAIN_CYCLES     = 300;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int item_count    = 0;
    int fail_count;
    int words_due;

    sha256_stream_hasher uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    sha256_digest_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    always #10 clk = ~clk;

    // digest receiver stalls at random
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // offer one byte word after a random gap and wait for its handshake
    task automatic send_word(input logic [7:0] data, input logic present,
                             input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        item_count++;
    endtask

    // message of random bytes with the odd empty word, closed on the last byte
    // or by a separate end word without a byte
    task automatic send_message(input int len, input bit split_end);
        int k;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, (k == len - 1) && !split_end);
        end
        if (len == 0 || split_end)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int phase;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 55;
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0) begin
                // empty message
                send_word(8'hFF, 1'b0, 1'b1);
                // empty word, then a single zero byte closing the message
                send_word(8'hA5, 1'b0, 1'b0);
                send_word(8'h00, 1'b1, 1'b1);
                // single all-ones byte, closed by an end word without a byte
                send_word(8'hFF, 1'b1, 1'b0);
                send_word(8'h00, 1'b0, 1'b1);
                // "abc" with an ignored word in between
                send_word(8'h61, 1'b1, 1'b0);
                send_word(8'h5A, 1'b0, 1'b0);
                send_word(8'h62, 1'b1, 1'b0);
                send_word(8'h63, 1'b1, 1'b1);
                // length field pushed into a second padding block
                send_message(56, 1'b0);
            end else if (phase == 1) begin
                // short random messages
                while (item_count < SHORT_MSG_TARGET)
                    send_message($urandom_range(0, 20), $urandom_range(0, 3) == 0);
            end else begin
                // full block, then an end word on an empty block
                send_message(64, 1'b1);
            end
        end
        s_tvalid <= 1'b0;

        // drain outstanding digests, then watch for stray words
        @(negedge clk);
        while (words_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && words_due == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
